// ----- rtl/core/byte_stream_word_line_counter_macros.svh -----
// Assertion macros for the byte stream counter.
`ifndef BYTE_STREAM_WORD_LINE_COUNTER_MACROS_SVH
`define BYTE_STREAM_WORD_LINE_COUNTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSWLC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BSWLC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/bswlc_pkg.sv -----
package bswlc_pkg;

    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_VT    = 8'h0b;
    localparam logic [7:0] CHAR_FF    = 8'h0c;
    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TILDE = 8'h7e;

    localparam int OUT_BITS = 32;
    localparam logic [2:0] TAB_MASK = 3'd7;

    typedef enum logic [2:0] {
        CLS_WORD,
        CLS_SPACE,
        CLS_TAB,
        CLS_LF,
        CLS_VT,
        CLS_BREAK,
        CLS_OTHER
    } byte_class_t;

endpackage

// ----- rtl/core/bswlc_classify.sv -----
module bswlc_classify
(
    input  logic [7:0]               data_byte,
    output bswlc_pkg::byte_class_t   cls
);

    always_comb
    begin
        priority if (data_byte >= bswlc_pkg::CHAR_SPACE && data_byte <= bswlc_pkg::CHAR_TILDE)
        begin
            cls = (data_byte == bswlc_pkg::CHAR_SPACE) ? bswlc_pkg::CLS_SPACE
                                                       : bswlc_pkg::CLS_WORD;
        end
        else
        begin
            unique case (data_byte)
                bswlc_pkg::CHAR_TAB: cls = bswlc_pkg::CLS_TAB;
                bswlc_pkg::CHAR_LF:  cls = bswlc_pkg::CLS_LF;
                bswlc_pkg::CHAR_VT:  cls = bswlc_pkg::CLS_VT;
                bswlc_pkg::CHAR_FF:  cls = bswlc_pkg::CLS_BREAK;
                bswlc_pkg::CHAR_CR:  cls = bswlc_pkg::CLS_BREAK;
                default:             cls = bswlc_pkg::CLS_OTHER;
            endcase
        end
    end

endmodule

// ----- rtl/core/bswlc_stream.sv -----
module bswlc_stream
#(
    parameter int COUNTER_BITS = 32
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  logic                       eos,
    input  bswlc_pkg::byte_class_t     cls,
    output logic [COUNTER_BITS-1:0]    fin_lines,
    output logic [COUNTER_BITS-1:0]    fin_words,
    output logic [COUNTER_BITS-1:0]    fin_bytes,
    output logic [COUNTER_BITS-1:0]    fin_width
);

    localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};
    localparam logic [COUNTER_BITS-1:0] CNT_ONE = COUNTER_BITS'(1);
    localparam logic [COUNTER_BITS-1:0] CNT_ZERO = '0;

    logic [COUNTER_BITS-1:0] lines_reg, lines_next;
    logic [COUNTER_BITS-1:0] words_reg, words_next;
    logic [COUNTER_BITS-1:0] bytes_reg, bytes_next;
    logic [COUNTER_BITS-1:0] width_reg, width_next;
    logic [COUNTER_BITS-1:0] column_reg, column_next;
    logic                    in_word_reg, in_word_next;

    logic [COUNTER_BITS-1:0] width_line;
    logic [COUNTER_BITS-1:0] words_close;
    logic [COUNTER_BITS-1:0] col_inc;
    logic [COUNTER_BITS-1:0] col_or;
    logic [COUNTER_BITS-1:0] col_tab;
    logic [COUNTER_BITS-1:0] lines_inc;
    logic [COUNTER_BITS-1:0] bytes_inc;

    always_comb
    begin
        width_line  = (column_reg > width_reg) ? column_reg : width_reg;
        words_close = (in_word_reg && words_reg != CNT_MAX) ? words_reg + CNT_ONE : words_reg;
        col_inc     = (column_reg == CNT_MAX) ? column_reg : column_reg + CNT_ONE;
        col_or      = column_reg | COUNTER_BITS'(bswlc_pkg::TAB_MASK);
        col_tab     = (col_or == CNT_MAX) ? CNT_MAX : col_or + CNT_ONE;
        lines_inc   = (lines_reg == CNT_MAX) ? lines_reg : lines_reg + CNT_ONE;
        bytes_inc   = (bytes_reg == CNT_MAX) ? bytes_reg : bytes_reg + CNT_ONE;
    end

    assign fin_lines = lines_reg;
    assign fin_words = words_close;
    assign fin_bytes = bytes_reg;
    assign fin_width = width_line;

    always_comb
    begin
        lines_next   = lines_reg;
        words_next   = words_reg;
        bytes_next   = bytes_reg;
        width_next   = width_reg;
        column_next  = column_reg;
        in_word_next = in_word_reg;
        if (step)
        begin
            if (eos)
            begin
                lines_next   = CNT_ZERO;
                words_next   = CNT_ZERO;
                bytes_next   = CNT_ZERO;
                width_next   = CNT_ZERO;
                column_next  = CNT_ZERO;
                in_word_next = 1'b0;
            end
            else
            begin
                bytes_next = bytes_inc;
                unique case (cls)
                    bswlc_pkg::CLS_WORD:
                    begin
                        column_next  = col_inc;
                        in_word_next = 1'b1;
                    end
                    bswlc_pkg::CLS_SPACE:
                    begin
                        column_next  = col_inc;
                        words_next   = words_close;
                        in_word_next = 1'b0;
                    end
                    bswlc_pkg::CLS_TAB:
                    begin
                        column_next  = col_tab;
                        words_next   = words_close;
                        in_word_next = 1'b0;
                    end
                    bswlc_pkg::CLS_LF:
                    begin
                        width_next   = width_line;
                        lines_next   = lines_inc;
                        column_next  = CNT_ZERO;
                        words_next   = words_close;
                        in_word_next = 1'b0;
                    end
                    bswlc_pkg::CLS_VT:
                    begin
                        width_next   = width_line;
                        words_next   = words_close;
                        in_word_next = 1'b0;
                    end
                    bswlc_pkg::CLS_BREAK:
                    begin
                        width_next   = width_line;
                        column_next  = CNT_ZERO;
                        words_next   = words_close;
                        in_word_next = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lines_reg   <= '0;
            words_reg   <= '0;
            bytes_reg   <= '0;
            width_reg   <= '0;
            column_reg  <= '0;
            in_word_reg <= 1'b0;
        end
        else
        begin
            lines_reg   <= lines_next;
            words_reg   <= words_next;
            bytes_reg   <= bytes_next;
            width_reg   <= width_next;
            column_reg  <= column_next;
            in_word_reg <= in_word_next;
        end
    end

endmodule

// ----- rtl/core/bswlc_totals.sv -----
module bswlc_totals
#(
    parameter int COUNTER_BITS = 32
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  logic [COUNTER_BITS-1:0]    fin_lines,
    input  logic [COUNTER_BITS-1:0]    fin_words,
    input  logic [COUNTER_BITS-1:0]    fin_bytes,
    input  logic [COUNTER_BITS-1:0]    fin_width,
    output logic [COUNTER_BITS-1:0]    tot_lines,
    output logic [COUNTER_BITS-1:0]    tot_words,
    output logic [COUNTER_BITS-1:0]    tot_bytes,
    output logic [COUNTER_BITS-1:0]    tot_width
);

    localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};

    logic [COUNTER_BITS-1:0] lines_reg;
    logic [COUNTER_BITS-1:0] words_reg;
    logic [COUNTER_BITS-1:0] bytes_reg;
    logic [COUNTER_BITS-1:0] width_reg;

    logic [COUNTER_BITS:0] lines_sum;
    logic [COUNTER_BITS:0] words_sum;
    logic [COUNTER_BITS:0] bytes_sum;

    always_comb
    begin
        lines_sum = {1'b0, lines_reg} + {1'b0, fin_lines};
        words_sum = {1'b0, words_reg} + {1'b0, fin_words};
        bytes_sum = {1'b0, bytes_reg} + {1'b0, fin_bytes};
        tot_lines = lines_sum[COUNTER_BITS] ? CNT_MAX : lines_sum[COUNTER_BITS-1:0];
        tot_words = words_sum[COUNTER_BITS] ? CNT_MAX : words_sum[COUNTER_BITS-1:0];
        tot_bytes = bytes_sum[COUNTER_BITS] ? CNT_MAX : bytes_sum[COUNTER_BITS-1:0];
        tot_width = (fin_width > width_reg) ? fin_width : width_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lines_reg <= '0;
            words_reg <= '0;
            bytes_reg <= '0;
            width_reg <= '0;
        end
        else if (step)
        begin
            lines_reg <= tot_lines;
            words_reg <= tot_words;
            bytes_reg <= tot_bytes;
            width_reg <= tot_width;
        end
    end

endmodule

// ----- rtl/core/byte_stream_word_line_counter.sv -----
// An end-of-stream item is held in the input register, and when it is processed its
// result is loaded into the result register. Throughput: one item per cycle; each
// item is handled between the input register and the counters, and an end-of-stream
// item waits only while the result register holds a result that is stalled.
// Reset clears all per-stream counters, the running totals and both valid flags.
`include "byte_stream_word_line_counter_macros.svh"

module byte_stream_word_line_counter
#(
    parameter int COUNTER_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  data_byte,
    input  logic        end_of_stream,
    output logic        count_valid,
    input  logic        count_stall,
    output logic [31:0] line_total,
    output logic [31:0] word_total,
    output logic [31:0] byte_total,
    output logic [31:0] longest_line,
    output logic [31:0] sum_lines,
    output logic [31:0] sum_words,
    output logic [31:0] sum_bytes,
    output logic [31:0] widest_overall
);

    function automatic logic [bswlc_pkg::OUT_BITS-1:0] low_word(
        input logic [COUNTER_BITS-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[bswlc_pkg::OUT_BITS-1:0];
    endfunction

    logic       in_full_reg, in_full_next;
    logic [7:0] in_byte_reg;
    logic       in_eos_reg;
    logic       out_valid_reg, out_valid_next;

    logic accept;
    logic res_room;
    logic proc;
    logic proc_eos;

    bswlc_pkg::byte_class_t cls;

    logic [COUNTER_BITS-1:0] fin_lines, fin_words, fin_bytes, fin_width;
    logic [COUNTER_BITS-1:0] tot_lines, tot_words, tot_bytes, tot_width;

    logic [31:0] line_total_reg, word_total_reg, byte_total_reg, longest_line_reg;
    logic [31:0] sum_lines_reg, sum_words_reg, sum_bytes_reg, widest_overall_reg;

    assign res_room   = !out_valid_reg || !count_stall;
    assign proc       = in_full_reg && (!in_eos_reg || res_room);
    assign proc_eos   = proc && in_eos_reg;
    assign byte_stall = in_full_reg && !proc;
    assign accept     = byte_valid && !byte_stall;

    always_comb
    begin
        in_full_next = in_full_reg;
        if (accept)
        begin
            in_full_next = 1'b1;
        end
        else if (proc)
        begin
            in_full_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (proc_eos)
        begin
            out_valid_next = 1'b1;
        end
        else if (!count_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_full_reg   <= in_full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= data_byte;
            in_eos_reg  <= end_of_stream;
        end
    end

    bswlc_classify u_classify
    (
        .data_byte (in_byte_reg),
        .cls       (cls)
    );

    bswlc_stream #(.COUNTER_BITS(COUNTER_BITS)) u_stream
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (proc),
        .eos       (in_eos_reg),
        .cls       (cls),
        .fin_lines (fin_lines),
        .fin_words (fin_words),
        .fin_bytes (fin_bytes),
        .fin_width (fin_width)
    );

    bswlc_totals #(.COUNTER_BITS(COUNTER_BITS)) u_totals
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (proc_eos),
        .fin_lines (fin_lines),
        .fin_words (fin_words),
        .fin_bytes (fin_bytes),
        .fin_width (fin_width),
        .tot_lines (tot_lines),
        .tot_words (tot_words),
        .tot_bytes (tot_bytes),
        .tot_width (tot_width)
    );

    always_ff @(posedge clk)
    begin
        if (proc_eos)
        begin
            line_total_reg     <= low_word(fin_lines);
            word_total_reg     <= low_word(fin_words);
            byte_total_reg     <= low_word(fin_bytes);
            longest_line_reg   <= low_word(fin_width);
            sum_lines_reg      <= low_word(tot_lines);
            sum_words_reg      <= low_word(tot_words);
            sum_bytes_reg      <= low_word(tot_bytes);
            widest_overall_reg <= low_word(tot_width);
        end
    end

    assign count_valid    = out_valid_reg;
    assign line_total     = line_total_reg;
    assign word_total     = word_total_reg;
    assign byte_total     = byte_total_reg;
    assign longest_line   = longest_line_reg;
    assign sum_lines      = sum_lines_reg;
    assign sum_words      = sum_words_reg;
    assign sum_bytes      = sum_bytes_reg;
    assign widest_overall = widest_overall_reg;

    `BSWLC_ASSERT_NEXT(a_eos_loads_result, proc_eos, out_valid_reg, "end of stream gave no result")
    `BSWLC_ASSERT_SAME(a_no_overwrite, out_valid_reg && count_stall, !proc_eos, "result lost")
    `BSWLC_ASSERT_NEXT(a_stream_cleared, proc_eos, fin_bytes == '0 && fin_lines == '0, "not cleared")
    `BSWLC_ASSERT_SAME(a_stall_only_on_eos, byte_stall, in_eos_reg && out_valid_reg, "bad stall")

endmodule
